[rtl/core/jsu_pkg.sv]
// Package for the JSON string unescape block: request and result types,
// status codes, character constants and small decode helpers.
// No dependencies.
package jsu_pkg;

    // Request: one raw byte of JSON text with its framing flags.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_req;
        logic       text_end;
    } t_req;

    // Result: one decoded byte, a done mark or an error mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last;
    } t_res;

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_LIM = 8'h20;

    localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // Returns {valid, value} for one hex digit in either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Number of UTF-8 bytes that a code point needs.
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80) begin
            n = 3'd1;
        end else if (cp < 21'h800) begin
            n = 3'd2;
        end else if (cp < 21'h10000) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // UTF-8 bytes of a code point, first byte in element 0.
    function automatic logic [3:0][7:0] utf8_bytes(input logic [20:0] cp);
        logic [3:0][7:0] b;
        b = '0;
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
        end else begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
        end
        return b;
    endfunction

endpackage

[rtl/core/json_string_unescape_utf8.sv]
// JSON string body decoder with UTF-8 output.
// Depends on jsu_pkg for the request/result types, codes and helpers.
//
// Usage: raw JSON text enters one byte per request on the req channel; a
// request with start_req set is the opening quote and arms the decoder.
// Plain bytes pass through, escapes and \uXXXX (with surrogate pairs) are
// decoded, and each code point leaves as one to four bytes on the res
// channel. The closing quote gives a done result; malformed or unterminated
// text gives an error result. The final result of each request has last set;
// a request may also give no result at all (idle bytes, a backslash).
// A request is held in an input register and decoded in a single pass into
// the result register, from which its results are offered on the res channel.
// Throughput: one request per cycle while each gives at most one result and
// the receiver takes every result; a request with several results holds the
// result register until all are taken; this sets the rate during UTF-8 bursts.
// Reset leaves the decoder idle with both registers empty. When the receiver
// stalls, the result register holds and the input register still takes one
// more request before req_ready falls.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req_data,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res_data
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_BODY  = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_HEX   = 3'd3;
    localparam logic [2:0] PH_HIW   = 3'd4;
    localparam logic [2:0] PH_HIBS  = 3'd5;
    localparam logic [2:0] PH_LOHEX = 3'd6;

    // Input register
    logic       r_in_valid;
    t_req       r_in;

    // Decoder state
    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_acc, n_code_acc;
    logic [9:0]  r_high_half, n_high_half;

    // Result register: a code point's bytes, then one single result, then an error.
    logic            r_busy;
    logic [2:0]      r_pos;
    logic [3:0][7:0] r_cp_bytes;
    logic [2:0]      r_cp_len;
    logic            r_s_en;
    logic [7:0]      r_s_byte;
    logic [1:0]      r_s_status;
    logic [2:0]      r_total;

    logic        res_take, res_last, drain, proc;
    logic        cp_en, s_en, err_en;
    logic [20:0] cp_val;
    logic [7:0]  s_byte;
    logic [1:0]  s_status;
    logic [2:0]  cp_len, n_total;

    // Per-byte outcomes of the body and escape rules.
    logic [2:0]  body_phase, esc_phase;
    logic        body_s, esc_s;
    logic [7:0]  body_byte, esc_byte;
    logic [1:0]  body_status, esc_status;
    logic        esc_is_u;
    logic [4:0]  hex;
    logic [15:0] acc_next;
    logic [20:0] lone_cp;

    assign res_take    = r_busy && i_res_ready;
    assign res_last    = (r_pos == r_total - 3'd1);
    assign drain       = !r_busy || (res_take && res_last);
    assign proc        = r_in_valid && drain;
    assign o_req_ready = !r_in_valid || drain;

    always_comb begin
        body_phase  = PH_BODY;
        body_s      = 1'b1;
        body_byte   = r_in.text_byte;
        body_status = ST_BYTE;
        if (r_in.text_byte == CH_QUOTE) begin
            body_phase  = PH_IDLE;
            body_byte   = 8'h00;
            body_status = ST_DONE;
        end else if (r_in.text_byte < CTRL_LIM) begin
            body_phase  = PH_IDLE;
            body_byte   = 8'h00;
            body_status = ST_ERR;
        end else if (r_in.text_byte == CH_BSL) begin
            body_phase = PH_ESC;
            body_s     = 1'b0;
        end
    end

    always_comb begin
        esc_phase  = PH_BODY;
        esc_s      = 1'b1;
        esc_status = ST_BYTE;
        esc_is_u   = 1'b0;
        esc_byte   = 8'h00;
        case (r_in.text_byte)
            CH_QUOTE: esc_byte = 8'h22;
            CH_BSL:   esc_byte = 8'h5C;
            CH_SLASH: esc_byte = 8'h2F;
            CH_B:     esc_byte = 8'h08;
            CH_F:     esc_byte = 8'h0C;
            CH_N:     esc_byte = 8'h0A;
            CH_R:     esc_byte = 8'h0D;
            CH_T:     esc_byte = 8'h09;
            CH_U: begin
                esc_phase = PH_HEX;
                esc_s     = 1'b0;
                esc_is_u  = 1'b1;
            end
            default: begin
                esc_phase  = PH_IDLE;
                esc_status = ST_ERR;
            end
        endcase
    end

    assign hex      = hex_digit(r_in.text_byte);
    assign acc_next = {r_code_acc[11:0], hex[3:0]};
    assign lone_cp  = {5'd0, SURR_HI_TAG, r_high_half};

    always_comb begin
        n_phase     = r_phase;
        n_hex_count = r_hex_count;
        n_code_acc  = r_code_acc;
        n_high_half = r_high_half;
        cp_en       = 1'b0;
        cp_val      = lone_cp;
        s_en        = 1'b0;
        s_byte      = 8'h00;
        s_status    = ST_ERR;
        err_en      = 1'b0;

        if (r_in.start_req) begin
            s_en        = (r_phase != PH_IDLE);
            n_phase     = PH_BODY;
            n_hex_count = 2'd0;
            n_code_acc  = 16'd0;
            n_high_half = 10'd0;
        end else begin
            unique case (r_phase) inside
                PH_BODY: begin
                    n_phase  = body_phase;
                    s_en     = body_s;
                    s_byte   = body_byte;
                    s_status = body_status;
                end
                PH_ESC: begin
                    n_phase  = esc_phase;
                    s_en     = esc_s;
                    s_byte   = esc_byte;
                    s_status = esc_status;
                    if (esc_is_u) begin
                        n_hex_count = 2'd0;
                        n_code_acc  = 16'd0;
                    end
                end
                PH_HEX, PH_LOHEX: begin
                    if (!hex[4]) begin
                        n_phase = PH_IDLE;
                        s_en    = 1'b1;
                    end else begin
                        n_code_acc  = acc_next;
                        n_hex_count = r_hex_count + 2'd1;
                        if (r_hex_count == 2'd3) begin
                            if (r_phase == PH_HEX) begin
                                if (acc_next[15:10] == SURR_HI_TAG) begin
                                    n_high_half = acc_next[9:0];
                                    n_phase     = PH_HIW;
                                end else begin
                                    cp_en   = 1'b1;
                                    cp_val  = {5'd0, acc_next};
                                    n_phase = PH_BODY;
                                end
                            end else if (acc_next[15:10] != SURR_LO_TAG) begin
                                n_phase = PH_IDLE;
                                s_en    = 1'b1;
                            end else begin
                                cp_en   = 1'b1;
                                cp_val  = SUPP_BASE + {1'b0, r_high_half, acc_next[9:0]};
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_HIW: begin
                    if (r_in.text_byte == CH_BSL) begin
                        n_phase = PH_HIBS;
                    end else begin
                        // Lone high surrogate goes out before the byte itself.
                        cp_en    = 1'b1;
                        n_phase  = body_phase;
                        s_en     = body_s;
                        s_byte   = body_byte;
                        s_status = body_status;
                    end
                end
                PH_HIBS: begin
                    if (r_in.text_byte == CH_U) begin
                        n_phase     = PH_LOHEX;
                        n_hex_count = 2'd0;
                        n_code_acc  = 16'd0;
                    end else begin
                        cp_en    = 1'b1;
                        n_phase  = esc_phase;
                        s_en     = esc_s;
                        s_byte   = esc_byte;
                        s_status = esc_status;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        // Text ends inside an open string: flush a pending high half, then fail.
        // A pending high half here never coincides with an earlier code point.
        if (r_in.text_end && n_phase != PH_IDLE) begin
            if (n_phase == PH_HIW || n_phase == PH_HIBS) begin
                cp_en  = 1'b1;
                cp_val = {5'd0, SURR_HI_TAG, n_high_half};
            end
            err_en  = 1'b1;
            n_phase = PH_IDLE;
        end
    end

    assign cp_len  = cp_en ? utf8_len(cp_val) : 3'd0;
    assign n_total = cp_len + {2'd0, s_en} + {2'd0, err_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_hex_count <= 2'd0;
            r_code_acc  <= 16'd0;
            r_high_half <= 10'd0;
            r_busy      <= 1'b0;
            r_pos       <= 3'd0;
        end else begin
            if (o_req_ready) begin
                r_in_valid <= i_req_valid;
            end
            if (proc) begin
                r_phase     <= n_phase;
                r_hex_count <= n_hex_count;
                r_code_acc  <= n_code_acc;
                r_high_half <= n_high_half;
            end
            if (proc && n_total != 3'd0) begin
                r_busy <= 1'b1;
                r_pos  <= 3'd0;
            end else if (res_take) begin
                if (res_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_in <= i_req_data;
        end
        if (proc && n_total != 3'd0) begin
            r_cp_bytes <= utf8_bytes(cp_val);
            r_cp_len   <= cp_len;
            r_s_en     <= s_en;
            r_s_byte   <= s_byte;
            r_s_status <= s_status;
            r_total    <= n_total;
        end
    end

    always_comb begin
        o_res_data.last = res_last;
        if (r_pos < r_cp_len) begin
            o_res_data.data_byte = r_cp_bytes[r_pos[1:0]];
            o_res_data.status    = ST_BYTE;
        end else if (r_pos == r_cp_len && r_s_en) begin
            o_res_data.data_byte = r_s_byte;
            o_res_data.status    = r_s_status;
        end else begin
            o_res_data.data_byte = 8'h00;
            o_res_data.status    = ST_ERR;
        end
    end

    assign o_res_valid = r_busy;

    // The result pointer never runs past the results of the current request.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < r_total && r_total != 3'd0))
        else $error("result pointer beyond result count");

    // A done result always closes the results of its request.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res_data.status == ST_DONE) |-> o_res_data.last)
        else $error("done result not marked last");

    // After a request that ends the text the decoder is idle.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in.text_end) |=> (r_phase == PH_IDLE))
        else $error("decoder still open after end of text");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the JSON string unescape block: a scoreboard
// class predicts the decoded bytes, done and error marks for each request.
// Depends on jsu_pkg and json_string_unescape_utf8.
module tb;
    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_RESULTS  = 5;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BODY,
        S_ESCAPE,
        S_HEX,
        S_HIGH_WAIT,
        S_HIGH_BSL,
        S_LOW_HEX
    } t_decode_state;

    class t_unescape_scoreboard;
        t_res          utf8_results_q[$];
        t_res          step_q[$];
        t_decode_state state;
        logic [1:0]    hex_count;
        logic [15:0]   code_acc;
        logic [9:0]    high_half;
        int unsigned   mismatches;
        int unsigned   decoded_requests;

        function new();
            state = S_IDLE;
            hex_count = 2'd0;
            code_acc = 16'd0;
            high_half = 10'd0;
            mismatches = 0;
            decoded_requests = 0;
        endfunction

        function int pending();
            return utf8_results_q.size();
        endfunction

        function void add_result(logic [7:0] b, logic [1:0] st);
            t_res r;
            if (step_q.size() >= MAX_RESULTS) return;
            r.data_byte = b;
            r.status = st;
            r.last = 1'b0;
            step_q.insert(step_q.size(), r);
        endfunction

        function void add_code_point(logic [20:0] cp);
            if (cp < 21'h80) begin
                add_result(cp[7:0], ST_BYTE);
            end else if (cp < 21'h800) begin
                add_result(8'hC0 | cp[10:6], ST_BYTE);
                add_result(8'h80 | cp[5:0], ST_BYTE);
            end else if (cp < 21'h10000) begin
                add_result(8'hE0 | cp[15:12], ST_BYTE);
                add_result(8'h80 | cp[11:6], ST_BYTE);
                add_result(8'h80 | cp[5:0], ST_BYTE);
            end else begin
                add_result(8'hF0 | cp[20:18], ST_BYTE);
                add_result(8'h80 | cp[17:12], ST_BYTE);
                add_result(8'h80 | cp[11:6], ST_BYTE);
                add_result(8'h80 | cp[5:0], ST_BYTE);
            end
        endfunction

        function void abandon();
            add_result(8'h00, ST_ERR);
            state = S_IDLE;
        endfunction

        function int hex_value(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
            if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
            if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
            return -1;
        endfunction

        function void body_char(logic [7:0] b);
            if (b == CH_QUOTE) begin
                add_result(8'h00, ST_DONE);
                state = S_IDLE;
            end else if (b < CTRL_LIM) begin
                abandon();
            end else if (b == CH_BSL) begin
                state = S_ESCAPE;
            end else begin
                add_result(b, ST_BYTE);
            end
        endfunction

        function void escape_char(logic [7:0] b);
            state = S_BODY;
            case (b)
                CH_QUOTE: add_result(CH_QUOTE, ST_BYTE);
                CH_BSL:   add_result(CH_BSL, ST_BYTE);
                CH_SLASH: add_result(CH_SLASH, ST_BYTE);
                CH_B:     add_result(8'h08, ST_BYTE);
                CH_F:     add_result(8'h0C, ST_BYTE);
                CH_N:     add_result(8'h0A, ST_BYTE);
                CH_R:     add_result(8'h0D, ST_BYTE);
                CH_T:     add_result(8'h09, ST_BYTE);
                CH_U: begin
                    state = S_HEX;
                    hex_count = 2'd0;
                    code_acc = 16'd0;
                end
                default:  abandon();
            endcase
        endfunction

        function void hex_char_in(logic [7:0] b, logic low_part);
            int d;
            d = hex_value(b);
            if (d < 0) begin
                abandon();
                return;
            end
            code_acc = {code_acc[11:0], d[3:0]};
            if (hex_count < 2'd3) begin
                hex_count++;
                return;
            end
            hex_count = 2'd0;
            if (!low_part) begin
                if (code_acc >= 16'hD800 && code_acc <= 16'hDBFF) begin
                    high_half = code_acc[9:0];
                    state = S_HIGH_WAIT;
                end else begin
                    add_code_point({5'd0, code_acc});
                    state = S_BODY;
                end
            end else if (code_acc < 16'hDC00 || code_acc > 16'hDFFF) begin
                abandon();
            end else begin
                add_code_point(21'h10000 + {high_half, code_acc[9:0]});
                state = S_BODY;
            end
        endfunction

        // Works out the results of one accepted request and queues them.
        function void note_request(t_req r);
            t_res t;
            step_q.delete();
            if (r.start_req || state != S_IDLE) decoded_requests++;
            if (r.start_req) begin
                if (state != S_IDLE) add_result(8'h00, ST_ERR);
                state = S_BODY;
                hex_count = 2'd0;
                code_acc = 16'd0;
                high_half = 10'd0;
            end else begin
                case (state)
                    S_BODY:    body_char(r.text_byte);
                    S_ESCAPE:  escape_char(r.text_byte);
                    S_HEX:     hex_char_in(r.text_byte, 1'b0);
                    S_LOW_HEX: hex_char_in(r.text_byte, 1'b1);
                    S_HIGH_WAIT: begin
                        if (r.text_byte == CH_BSL) begin
                            state = S_HIGH_BSL;
                        end else begin
                            add_code_point(21'hD800 + high_half);
                            state = S_BODY;
                            body_char(r.text_byte);
                        end
                    end
                    S_HIGH_BSL: begin
                        if (r.text_byte == CH_U) begin
                            state = S_LOW_HEX;
                            hex_count = 2'd0;
                            code_acc = 16'd0;
                        end else begin
                            add_code_point(21'hD800 + high_half);
                            escape_char(r.text_byte);
                        end
                    end
                    default:   state = S_IDLE;
                endcase
            end
            if (r.text_end && state != S_IDLE) begin
                // A high surrogate still waiting for its partner goes out first.
                if (state == S_HIGH_WAIT || state == S_HIGH_BSL) begin
                    add_code_point(21'hD800 + high_half);
                end
                abandon();
            end
            foreach (step_q[i]) begin
                t = step_q[i];
                t.last = (i == step_q.size() - 1);
                utf8_results_q.insert(utf8_results_q.size(), t);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (utf8_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: byte %02h status %0d last %0b",
                             got.data_byte, got.status, got.last);
                end
                return;
            end
            want = utf8_results_q.pop_front();
            if (got.data_byte !== want.data_byte || got.status !== want.status ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                             want.data_byte, want.status, want.last,
                             got.data_byte, got.status, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req_data;
    logic o_res_valid;
    logic i_res_ready;
    t_res o_res_data;

    t_unescape_scoreboard sb;
    logic no_idle;
    logic sender_gaps;
    int   cycles;

    json_string_unescape_utf8 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req_data  (i_req_data),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_data  (o_res_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) sb.check_result(o_res_data);
    end

    // Receiver: random stall bursts, broken by calm stretches.
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        i_res_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (no_idle) stall_left = 0;
            if (stall_left > 0) begin
                i_res_ready <= 1'b0;
                stall_left--;
            end else begin
                i_res_ready <= 1'b1;
                if (!no_idle) begin
                    if (calm_left > 0) begin
                        calm_left--;
                    end else if ($urandom_range(0, 31) == 0) begin
                        calm_left = $urandom_range(20, 120);
                    end else if ($urandom_range(0, 5) == 0) begin
                        stall_left = $urandom_range(1, 19);
                    end
                end
            end
        end
    end

    task automatic send_request(logic [7:0] b, logic start, logic fin);
        t_req r;
        int gap;
        r.text_byte = b;
        r.start_req = start;
        r.text_end = fin;
        if (!no_idle && sender_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_req_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_req_data <= r;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(r);
    endtask

    // Holds the sender back until every queued result has been seen.
    task automatic drain_results();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // In-string bytes occasionally carry the end-of-text flag.
    task automatic send_body(logic [7:0] b);
        send_request(b, 1'b0, $urandom_range(0, 99) == 0);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_request(s[i], 1'b0, 1'b0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
    endfunction

    task automatic send_unicode(logic [15:0] v);
        send_body(CH_BSL);
        send_body(CH_U);
        send_body(hex_char(v[15:12]));
        send_body(hex_char(v[11:8]));
        send_body(hex_char(v[7:4]));
        send_body(hex_char(v[3:0]));
    endtask

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 7))
            0:       return CH_QUOTE;
            1:       return CH_BSL;
            2:       return CH_SLASH;
            3:       return CH_B;
            4:       return CH_F;
            5:       return CH_N;
            6:       return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(8'h20, 8'hFF));
        if (b == CH_QUOTE || b == CH_BSL) b = 8'h20;
        return b;
    endfunction

    function automatic logic [15:0] bmp_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    task automatic good_token();
        case ($urandom_range(0, 10))
            0, 1, 2: send_body(plain_char());
            3:       send_body(8'($urandom_range(8'h80, 8'hFF)));
            4, 5: begin
                send_body(CH_BSL);
                send_body(escape_letter());
            end
            6, 7:    send_unicode(bmp_value());
            8: begin
                send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            9: begin
                if ($urandom_range(0, 1))
                    send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                else
                    send_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            default: begin
                // High half followed by a plain escape rather than its partner.
                send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_body(CH_BSL);
                send_body(escape_letter());
            end
        endcase
    endtask

    task automatic bad_token();
        int k;
        case ($urandom_range(0, 3))
            0: send_body(8'($urandom_range(8'h00, 8'h1F)));
            1: begin
                send_body(CH_BSL);
                send_body(8'($urandom_range(0, 255)));
            end
            2: begin
                send_body(CH_BSL);
                send_body(CH_U);
                k = $urandom_range(0, 3);
                repeat (k) send_body(hex_char(4'($urandom_range(0, 15))));
                send_body(8'($urandom_range(0, 255)));
            end
            default: begin
                send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                if ($urandom_range(0, 1))
                    send_unicode(16'($urandom_range(16'h0000, 16'hDBFF)));
                else
                    send_unicode(16'($urandom_range(16'hE000, 16'hFFFF)));
            end
        endcase
    endtask

    task automatic random_string();
        int n_tokens;
        int finish;
        sender_gaps = ($urandom_range(0, 3) != 0);
        send_request(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 15) == 0);
        n_tokens = $urandom_range(1, 8);
        repeat (n_tokens) good_token();
        if ($urandom_range(0, 4) == 0) begin
            bad_token();
        end else begin
            finish = $urandom_range(0, 9);
            if (finish < 7) send_request(CH_QUOTE, 1'b0, 1'b0);
            else if (finish < 9) send_request(plain_char(), 1'b0, 1'b1);
            // Otherwise the string stays open until a later end-of-text flag or start abandons it.
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_request(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1) == 1);
            end
        end
    endtask

    initial begin
        int base;
        logic midway_drained;
        sb = new();
        no_idle = 1'b0;
        sender_gaps = 1'b1;
        midway_drained = 1'b0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: idle byte, extremes, control byte, surrogate pair,
        // done, lone high half cut off by end of text, and a restart.
        send_request(8'h41, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(CH_QUOTE, 1'b1, 1'b0);
        send_text("\\ud83D\\uDE00\\n\"");
        send_request(CH_QUOTE, 1'b1, 1'b0);
        send_text("\\uDBFF");
        send_request(8'h7E, 1'b0, 1'b1);
        send_request(CH_QUOTE, 1'b1, 1'b0);
        send_request(CH_QUOTE, 1'b1, 1'b1);
        drain_results();

        base = sb.decoded_requests;
        while (sb.decoded_requests < base + RANDOM_ITEMS) begin
            if (!midway_drained && sb.decoded_requests >= base + RANDOM_ITEMS / 2) begin
                drain_results();
                midway_drained = 1'b1;
            end
            if (sb.decoded_requests >= base + RANDOM_ITEMS - 40) no_idle = 1'b1;
            random_string();
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
